FILE: hdl/ebwc_pkg.sv
`timescale 1ns / 1ps

package ebwc_pkg;

  localparam int unsigned DigitBits   = 7;
  localparam int unsigned MaxSeqBytes = 4;
  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 3;
  localparam int unsigned CountW      = 3;
  localparam int unsigned WideCharW   = 30;
  localparam int unsigned CodeW       = WideCharW - 2;
  localparam int unsigned CfgIdxW     = 2;

  localparam logic [ByteW-1:0] Ss2Byte    = 8'h8E;
  localparam logic [ByteW-1:0] Ss3Byte    = 8'h8F;
  localparam logic [ByteW-1:0] C1First    = 8'h80;
  localparam logic [ByteW-1:0] GraphFirst = 8'hA0;

  typedef enum logic [1:0] {
    StatDone    = 2'd0,
    StatIllegal = 2'd1,
    StatEnd     = 2'd2,
    StatBadLen  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SetNone = 2'd0,
    Set1    = 2'd1,
    Set2    = 2'd2,
    Set3    = 2'd3
  } code_set_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSet1Len = 2'd0,
    CfgSet2Len = 2'd1,
    CfgSet3Len = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_input;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [WideCharW-1:0] wide_char;
    logic [CountW-1:0]    byte_count;
    logic                 retry_valid;
    logic [ByteW-1:0]     retry_byte;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [LenW-1:0]    data;
  } cfg_item_t;

  typedef struct packed {
    logic [LenW-1:0] set1_len;
    logic [LenW-1:0] set2_len;
    logic [LenW-1:0] set3_len;
  } lengths_t;

  function automatic logic [LenW-1:0] clamp_len(logic [LenW-1:0] v, logic [LenW-1:0] max_len);
    return (v > max_len) ? max_len : v;
  endfunction

  // top two bits of the wide character for each code set
  function automatic logic [1:0] tag_bits(code_set_e s);
    logic [1:0] t;
    unique case (s)
      Set1:    t = 2'b11;
      Set2:    t = 2'b01;
      Set3:    t = 2'b10;
      default: t = 2'b00;
    endcase
    return t;
  endfunction

endpackage

FILE: hdl/ebwc_chan_if.sv
`timescale 1ns / 1ps

interface ebwc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ebwc_cfg_regs.sv
`timescale 1ns / 1ps

module ebwc_cfg_regs import ebwc_pkg::*; #(
  parameter int unsigned MAX_SEQ_BYTES = MaxSeqBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  cfg_item_t cfg_item_i,
  output lengths_t  lengths_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_SEQ_BYTES);

  lengths_t lengths_q, lengths_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    lengths_d = lengths_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_item_i.index))
        CfgSet1Len: lengths_d.set1_len = clamp_len(cfg_item_i.data, MaxLen);
        CfgSet2Len: lengths_d.set2_len = clamp_len(cfg_item_i.data, MaxLen);
        CfgSet3Len: lengths_d.set3_len = clamp_len(cfg_item_i.data, MaxLen);
        default: lengths_d = lengths_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lengths_q.set1_len <= clamp_len(3'd2, MaxLen);
      lengths_q.set2_len <= clamp_len(3'd1, MaxLen);
      lengths_q.set3_len <= clamp_len(3'd2, MaxLen);
    end else begin
      lengths_q <= lengths_d;
    end
  end

  assign lengths_o = lengths_q;

endmodule

FILE: hdl/ebwc_in_reg.sv
`timescale 1ns / 1ps

module ebwc_in_reg import ebwc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     item_valid_o,
  input  logic     item_take_i,
  output in_item_t item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;

  assign in_ready_o = !valid_q || item_take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

FILE: hdl/ebwc_core.sv
`timescale 1ns / 1ps

module ebwc_core import ebwc_pkg::*; #(
  parameter int unsigned MAX_SEQ_BYTES = MaxSeqBytes
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lengths_t  lengths_i,
  input  logic      item_valid_i,
  output logic      item_take_o,
  input  in_item_t  item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned AccW = DigitBits * MAX_SEQ_BYTES;

  logic              collecting_q, collecting_d;
  logic [CountW-1:0] left_q, left_d;
  logic [CountW-1:0] taken_q, taken_d;
  code_set_e         tag_q, tag_d;
  logic [AccW-1:0]   acc_q, acc_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q;

  logic              emit;
  out_item_t         res;
  logic [ByteW-1:0]  b;
  logic [AccW-1:0]   acc_shift;
  logic [CountW-1:0] taken_inc;

  assign item_take_o = item_valid_i && (!out_valid_q || out_ready_i);
  assign b           = item_i.in_byte;
  assign acc_shift   = AccW'({acc_q, b[DigitBits-1:0]});
  assign taken_inc   = taken_q + CountW'(1);

  always_comb begin
    collecting_d = collecting_q;
    left_d       = left_q;
    taken_d      = taken_q;
    tag_d        = tag_q;
    acc_d        = acc_q;
    emit         = 1'b0;
    res          = '0;
    res.status   = StatDone;
    if (item_take_o) begin
      if (collecting_q) begin
        if (item_i.end_of_input) begin
          emit           = 1'b1;
          res.status     = StatIllegal;
          res.byte_count = taken_q;
          collecting_d   = 1'b0;
        end else if (b < GraphFirst) begin
          emit            = 1'b1;
          res.status      = StatIllegal;
          res.byte_count  = taken_q;
          res.retry_valid = 1'b1;
          res.retry_byte  = b;
          collecting_d    = 1'b0;
        end else if (left_q == CountW'(1)) begin
          emit           = 1'b1;
          res.wide_char  = {tag_bits(tag_q), CodeW'(acc_shift)};
          res.byte_count = taken_inc;
          collecting_d   = 1'b0;
        end else begin
          acc_d   = acc_shift;
          taken_d = taken_inc;
          left_d  = left_q - CountW'(1);
        end
      end else begin
        if (item_i.end_of_input) begin
          emit       = 1'b1;
          res.status = StatEnd;
        end else if (b < C1First) begin
          emit           = 1'b1;
          res.wide_char  = WideCharW'(b);
          res.byte_count = CountW'(1);
        end else if (b == Ss2Byte && lengths_i.set2_len != '0) begin
          collecting_d = 1'b1;
          left_d       = lengths_i.set2_len;
          acc_d        = '0;
          tag_d        = Set2;
          taken_d      = CountW'(1);
        end else if (b == Ss3Byte && lengths_i.set3_len != '0) begin
          collecting_d = 1'b1;
          left_d       = lengths_i.set3_len;
          acc_d        = '0;
          tag_d        = Set3;
          taken_d      = CountW'(1);
        end else if (b < GraphFirst) begin
          emit           = 1'b1;
          res.wide_char  = WideCharW'(b);
          res.byte_count = CountW'(1);
        end else if (lengths_i.set1_len == '0) begin
          emit           = 1'b1;
          res.status     = StatBadLen;
          res.byte_count = CountW'(1);
        end else if (lengths_i.set1_len == LenW'(1)) begin
          emit           = 1'b1;
          res.wide_char  = {tag_bits(Set1), CodeW'(b[DigitBits-1:0])};
          res.byte_count = CountW'(1);
        end else begin
          collecting_d = 1'b1;
          left_d       = lengths_i.set1_len - LenW'(1);
          acc_d        = AccW'(b[DigitBits-1:0]);
          tag_d        = Set1;
          taken_d      = CountW'(1);
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (item_take_o && emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      collecting_q <= 1'b0;
      left_q       <= '0;
      taken_q      <= '0;
      tag_q        <= SetNone;
      out_valid_q  <= 1'b0;
    end else begin
      collecting_q <= collecting_d;
      left_q       <= left_d;
      taken_q      <= taken_d;
      tag_q        <= tag_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (item_take_o && emit) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: hdl/euc_byte_to_wide_char_decoder.sv
`timescale 1ns / 1ps
// a byte is held in the input register, then its result in the result register
// a byte per cycle unless out_o stalls; a byte ending no character updates state, shows nothing
// the input register frees whenever the result register is empty or is being drained
// reset: decoder idle, no result pending, lengths set1 2, set2 1, set3 2
// lengths above the maximum sequence size saturate when written

module euc_byte_to_wide_char_decoder import ebwc_pkg::*; #(
  parameter int unsigned MAX_SEQ_BYTES = MaxSeqBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ebwc_chan_if.sink   in_i,
  ebwc_chan_if.source out_o,
  ebwc_chan_if.sink   cfg_i
);

  lengths_t  lengths;
  logic      item_valid;
  logic      item_take;
  in_item_t  item;
  out_item_t out_item;

  ebwc_cfg_regs #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
  ) u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .cfg_item_i  (cfg_i.payload),
    .lengths_o   (lengths)
  );

  ebwc_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_item_i    (in_i.payload),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  ebwc_core #(
    .MAX_SEQ_BYTES(MAX_SEQ_BYTES)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .lengths_i    (lengths),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_item_o   (out_item)
  );

  assign out_o.payload = out_item;

endmodule

FILE: hdl/ebwc_checker.sv
`timescale 1ns / 1ps

module ebwc_checker import ebwc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_item_i
);

  // a pending transaction holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_item_i))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.status != StatDone |-> out_item_i.wide_char == '0)
    else $error("wide char set on a failed transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_item_i.retry_valid |->
      out_item_i.status == StatIllegal && out_item_i.retry_byte < GraphFirst)
    else $error("retry byte on a non-illegal result or not a control byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_item_i.status == StatEnd) == (out_item_i.byte_count == '0))
    else $error("byte count inconsistent with end of input");

endmodule

bind euc_byte_to_wide_char_decoder ebwc_checker u_ebwc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_item_i  (out_o.payload)
);

FILE: dv/tb_euc_byte_to_wide_char_decoder.sv
`timescale 1ns / 1ps

module tb_euc_byte_to_wide_char_decoder;
  import ebwc_pkg::*;

  localparam int unsigned StallLimit  = 500;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned MaxReports  = 10;
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;
  localparam logic [ByteW-1:0] AsciiLast = 8'h7F;
  localparam logic [ByteW-1:0] ByteMax   = 8'hFF;
  // tag bits per code set, two bits per entry, SetNone first
  localparam logic [7:0] TagTable = 8'b10_01_11_00;

  logic clk;
  logic rst_n;

  ebwc_chan_if #(.payload_t(in_item_t))  in_if ();
  ebwc_chan_if #(.payload_t(out_item_t)) out_if ();
  ebwc_chan_if #(.payload_t(cfg_item_t)) cfg_if ();

  euc_byte_to_wide_char_decoder DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  out_item_t       expected_q[$];
  int unsigned     mismatch_cnt = 0;
  int unsigned     bytes_sent   = 0;
  bit              idle_en      = 1'b1;
  int unsigned     gap_pct      = 20;
  int unsigned     stall_pct    = 20;

  logic [LenW-1:0] len_reg [3];
  bit              dec_busy;
  logic [LenW-1:0] dec_left;
  logic [CountW-1:0] dec_taken;
  logic [CodeW-1:0] dec_code;
  code_set_e       dec_set;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [LenW-1:0] limit_len(input logic [LenW-1:0] v);
    return (v > LenW'(MaxSeqBytes)) ? LenW'(MaxSeqBytes) : v;
  endfunction

  function automatic logic [ByteW-1:0] graphic_byte();
    return ByteW'($urandom_range(GraphFirst, ByteMax));
  endfunction

  function automatic logic [1:0] tag_of(input code_set_e s);
    return TagTable[int'(s) * 2 +: 2];
  endfunction

  // returns 1 when the byte completes a character, an error or the end of input
  function automatic bit decode_byte(input in_item_t it, output out_item_t r);
    logic [ByteW-1:0] b;
    logic [LenW-1:0]  len;
    b = it.in_byte;
    r = '0;
    if (dec_busy) begin
      r.byte_count = dec_taken;
      if (it.end_of_input || b < GraphFirst) begin
        r.status = StatIllegal;
        if (!it.end_of_input) begin
          r.retry_valid = 1'b1;
          r.retry_byte  = b;
        end
        dec_busy = 1'b0;
        return 1'b1;
      end
      dec_code = {dec_code[CodeW-DigitBits-1:0], b[DigitBits-1:0]};
      dec_taken++;
      dec_left--;
      if (dec_left != 0) return 1'b0;
      r.status     = StatDone;
      r.wide_char  = {tag_of(dec_set), dec_code};
      r.byte_count = dec_taken;
      dec_busy     = 1'b0;
      return 1'b1;
    end
    if (it.end_of_input) begin
      r.status = StatEnd;
      return 1'b1;
    end
    if ((b == Ss2Byte && limit_len(len_reg[CfgSet2Len]) != 0) ||
        (b == Ss3Byte && limit_len(len_reg[CfgSet3Len]) != 0)) begin
      if (b == Ss2Byte) begin
        dec_set  = Set2;
        dec_left = limit_len(len_reg[CfgSet2Len]);
      end else begin
        dec_set  = Set3;
        dec_left = limit_len(len_reg[CfgSet3Len]);
      end
      dec_code  = '0;
      dec_taken = CountW'(1);
      dec_busy  = 1'b1;
      return 1'b0;
    end
    r.byte_count = CountW'(1);
    if (b < GraphFirst) begin
      r.status    = StatDone;
      r.wide_char = WideCharW'(b);
      return 1'b1;
    end
    len = limit_len(len_reg[CfgSet1Len]);
    if (len == 0) begin
      r.status = StatBadLen;
      return 1'b1;
    end
    if (len == 1) begin
      r.status    = StatDone;
      r.wide_char = {tag_of(Set1), CodeW'(b[DigitBits-1:0])};
      return 1'b1;
    end
    dec_set   = Set1;
    dec_left  = len - LenW'(1);
    dec_code  = CodeW'(b[DigitBits-1:0]);
    dec_taken = CountW'(1);
    dec_busy  = 1'b1;
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [ByteW-1:0] b, input bit eoi);
    in_item_t  it;
    out_item_t r;
    it.in_byte      = b;
    it.end_of_input = eoi;
    in_if.payload <= it;
    in_if.valid   <= 1'b1;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (decode_byte(it, r)) expected_q.push_back(r);
    bytes_sent++;
    if (idle_en && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic quiesce();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_len(input logic [CfgIdxW-1:0] idx, input logic [LenW-1:0] v);
    cfg_if.payload <= cfg_item_t'{index: idx, data: v};
    cfg_if.valid   <= 1'b1;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx <= CfgSet3Len) len_reg[idx] = v;
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [LenW-1:0] pick_len();
    case ($urandom_range(0, 4))
      0:       return LenW'(0);
      1:       return LenW'(7);
      2:       return LenW'(MaxSeqBytes);
      default: return LenW'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic write_random_lengths();
    write_len(CfgSet1Len, pick_len());
    write_len(CfgSet2Len, pick_len());
    write_len(CfgSet3Len, pick_len());
  endtask

  task automatic send_unit();
    logic [LenW-1:0] l1;
    logic [LenW-1:0] l2;
    logic [LenW-1:0] l3;
    int unsigned     kind;
    l1   = limit_len(len_reg[CfgSet1Len]);
    l2   = limit_len(len_reg[CfgSet2Len]);
    l3   = limit_len(len_reg[CfgSet3Len]);
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      send_byte(ByteW'($urandom_range(0, GraphFirst - 1)), 1'b0);
    end else if (kind < 50) begin
      send_byte(graphic_byte(), 1'b0);
      for (int i = 1; i < l1; i++) send_byte(graphic_byte(), 1'b0);
    end else if (kind < 65) begin
      send_byte(Ss2Byte, 1'b0);
      for (int i = 0; i < l2; i++) send_byte(graphic_byte(), 1'b0);
    end else if (kind < 80) begin
      send_byte(Ss3Byte, 1'b0);
      for (int i = 0; i < l3; i++) send_byte(graphic_byte(), 1'b0);
    end else if (kind < 92) begin
      // sequence that may be cut short by a control byte or by end of input
      send_byte($urandom_range(0, 1) ? Ss3Byte : graphic_byte(), 1'b0);
      repeat ($urandom_range(0, 2)) send_byte(graphic_byte(), 1'b0);
      if ($urandom_range(0, 2) == 0) send_byte(ByteW'($urandom), 1'b1);
      else send_byte(ByteW'($urandom_range(0, GraphFirst - 1)), 1'b0);
    end else begin
      send_byte(ByteW'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_reset_lengths();
    send_byte(8'h00, 1'b0);
    send_byte(AsciiLast, 1'b0);
    send_byte(C1First, 1'b0);
    send_byte(GraphFirst - 8'd1, 1'b0);
    send_byte(Ss2Byte, 1'b0);
    send_byte(8'hA1, 1'b0);
    send_byte(Ss3Byte, 1'b0);
    send_byte(ByteMax, 1'b0);
    send_byte(GraphFirst, 1'b0);
    send_byte(GraphFirst, 1'b0);
    send_byte(ByteMax, 1'b0);
    send_byte(8'hB0, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(Ss3Byte, 1'b0);
    send_byte(8'hC5, 1'b0);
    send_byte(Ss2Byte, 1'b0);
    send_byte(Ss2Byte, 1'b0);
    send_byte(8'hD2, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(ByteMax, 1'b1);
    quiesce();
  endtask

  task automatic test_length_extremes();
    write_len(CfgSet1Len, 3'd0);
    send_byte(8'hA5, 1'b0);
    quiesce();
    write_len(CfgSet1Len, 3'd1);
    write_len(CfgSet2Len, 3'd0);
    write_len(CfgSet3Len, 3'd0);
    send_byte(ByteMax, 1'b0);
    send_byte(Ss2Byte, 1'b0);
    send_byte(Ss3Byte, 1'b0);
    quiesce();
    write_len(CfgSet1Len, 3'd7);
    write_len(CfgSet2Len, 3'd5);
    write_len(CfgSet3Len, 3'd6);
    write_len(CfgUnused, 3'd7);
    send_byte(GraphFirst, 1'b0);
    send_byte(ByteMax, 1'b0);
    send_byte(GraphFirst, 1'b0);
    send_byte(ByteMax, 1'b0);
    send_byte(Ss3Byte, 1'b0);
    repeat (4) send_byte(ByteMax, 1'b0);
    quiesce();
  endtask

  task automatic test_random_mix();
    int unsigned target;
    for (int phase = 0; phase < 8; phase++) begin
      write_random_lengths();
      gap_pct   = (phase % 3 == 0) ? 0 : $urandom_range(5, 40);
      stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(5, 40);
      target    = bytes_sent + 140;
      while (bytes_sent < target) begin
        send_unit();
        if ($urandom_range(0, 199) == 0) quiesce();
      end
      quiesce();
    end
  endtask

  task automatic test_full_rate();
    int unsigned target;
    write_random_lengths();
    idle_en = 1'b0;
    target  = bytes_sent + 200;
    while (bytes_sent < target) send_unit();
    quiesce();
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReports)
          $display("unexpected transaction: st=%0d wc=%h cnt=%0d rv=%b rb=%h",
                   got.status, got.wide_char, got.byte_count, got.retry_valid,
                   got.retry_byte);
      end else begin
        want = expected_q.pop_front();
        if (want.status !== got.status || want.wide_char !== got.wide_char ||
            want.byte_count !== got.byte_count || want.retry_valid !== got.retry_valid ||
            want.retry_byte !== got.retry_byte) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MaxReports)
            $display({"mismatch: exp st=%0d wc=%h cnt=%0d rv=%b rb=%h, ",
                      "got st=%0d wc=%h cnt=%0d rv=%b rb=%h"},
                     want.status, want.wide_char, want.byte_count, want.retry_valid,
                     want.retry_byte, got.status, got.wide_char, got.byte_count,
                     got.retry_valid, got.retry_byte);
        end
      end
    end
  end

  // result side backpressure
  initial begin
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_en && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_n);
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.payload  <= '0;
    cfg_if.valid   <= 1'b0;
    cfg_if.payload <= '0;
    len_reg[CfgSet1Len] = 3'd2;
    len_reg[CfgSet2Len] = 3'd1;
    len_reg[CfgSet3Len] = 3'd2;
    dec_busy  = 1'b0;
    dec_left  = '0;
    dec_taken = '0;
    dec_code  = '0;
    dec_set   = SetNone;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_lengths();
    test_length_extremes();
    test_random_mix();
    test_full_rate();
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
